### rtl/mma_pkg.sv
package mma_pkg;

  localparam int DefMaxPoints    = 256;
  localparam int DefMaxCentroids = 16;

  localparam int ActW     = 2;
  localparam int PointW   = 9;
  localparam int CentW    = 5;
  localparam int ValW     = 16;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 9;
  localparam int InDataW  = 32;
  localparam int OutDataW = 32;
  localparam int OutUserW = 1;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgPoints    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCentroids = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgIndexBase = 2'd2;

  localparam logic [PointW-1:0] PointsReset    = 9'd256;
  localparam logic [CentW-1:0]  CentroidsReset = 5'd16;

  typedef enum logic [1:0] {
    ACT_WRITE,
    ACT_READ,
    ACT_HARD,
    ACT_COUNT
  } act_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } seq_state_e;

  // one entry of a row scan, aligned with the memory read data
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic             fin;
    logic [CentW-1:0] col;
  } scan_beat_t;

  typedef struct packed {
    logic             done;
    logic             fin;
    logic [CentW-1:0] col;
  } argmax_res_t;

  typedef struct packed {
    logic [ValW-1:0]   read_value;
    logic [CentW-1:0]  cluster_index;
    logic [PointW-1:0] point_count;
    logic              status;
  } result_t;

endpackage

### rtl/membership_matrix_argmax.sv
// Membership matrix with hard cluster lookup.
// Input beats on s_axis carry an action (write, read, hard cluster, count),
// a biased point row, a biased centroid column and a membership value.
// Every input beat produces exactly one output beat on m_axis holding the
// read value, the hard cluster, the member count and an out-of-range flag.
// The configuration port sets rows in use, columns in use and index base;
// write it only while no item is in flight.
// One item at a time: s_axis_tready is high only while the sequencer idles.
// Write, read and out-of-range items go from accept to the result state
// and then into the output register. A hard cluster walks one row through
// the single compare unit, one entry per cycle from the memory read port.
// A count walks every row in use.
// Reset clears the sequencer and output valid and restores the configuration
// (256 rows, 16 columns, base 0); the memory is not cleared, and an entry
// must be written before it is read. A finished result waits in the output
// register while m_axis_tready is low; the next input beat is taken then but
// its result is held back until the register frees up.
module membership_matrix_argmax #(
  parameter int MAX_POINTS    = mma_pkg::DefMaxPoints,
  parameter int MAX_CENTROIDS = mma_pkg::DefMaxCentroids
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mma_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [mma_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // action[1:0], point[10:2], centroid[15:11], membership_value[31:16]
  input  logic [mma_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // read_value[15:0], cluster_index[20:16], point_count[29:21], zero fill
  output logic [mma_pkg::OutDataW-1:0]   m_axis_tdata,
  // status[0]
  output logic [mma_pkg::OutUserW-1:0]   m_axis_tuser
);
  import mma_pkg::*;

  localparam int Depth = MAX_POINTS * MAX_CENTROIDS;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;

  logic [PointW-1:0] cfg_points_q;
  logic [CentW-1:0]  cfg_cents_q;
  logic              cfg_base_q;
  logic [PointW-1:0] np_eff;
  logic [CentW-1:0]  nc_eff;

  logic              out_valid_q;
  result_t           out_q;
  logic              out_free;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [ValW-1:0]   ram_wdata, ram_rdata;
  scan_beat_t        beat;
  argmax_res_t       amax_res;
  logic              load;
  result_t           result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_points_q <= PointsReset;
      cfg_cents_q  <= CentroidsReset;
      cfg_base_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPoints:    cfg_points_q <= cfg_data_i;
        CfgCentroids: cfg_cents_q  <= cfg_data_i[CentW-1:0];
        CfgIndexBase: cfg_base_q   <= cfg_data_i[0];
        default:      ;
      endcase
    end
  end

  // saturate the in-use counts to 1 .. maximum
  always_comb begin
    if (cfg_points_q == '0) begin
      np_eff = PointW'(1);
    end else if (32'(cfg_points_q) > MAX_POINTS) begin
      np_eff = PointW'(MAX_POINTS);
    end else begin
      np_eff = cfg_points_q;
    end
    if (cfg_cents_q == '0) begin
      nc_eff = CentW'(1);
    end else if (32'(cfg_cents_q) > MAX_CENTROIDS) begin
      nc_eff = CentW'(MAX_CENTROIDS);
    end else begin
      nc_eff = cfg_cents_q;
    end
  end

  mma_ram #(
    .Width (ValW),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  mma_argmax u_argmax (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (beat),
    .data_i (ram_rdata),
    .res_o  (amax_res)
  );

  mma_seq #(
    .MAX_POINTS    (MAX_POINTS),
    .MAX_CENTROIDS (MAX_CENTROIDS),
    .AW            (AW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .action_i    (s_axis_tdata[1:0]),
    .point_i     (s_axis_tdata[10:2]),
    .centroid_i  (s_axis_tdata[15:11]),
    .value_i     (s_axis_tdata[31:16]),
    .np_i        (np_eff),
    .nc_i        (nc_eff),
    .base_i      (cfg_base_q),
    .out_free_i  (out_free),
    .res_i       (amax_res),
    .rdata_i     (ram_rdata),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .beat_o      (beat),
    .load_o      (load),
    .result_o    (result)
  );

  // output register parts the sequencer from the receiver
  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.point_count, out_q.cluster_index, out_q.read_value};
  assign m_axis_tuser  = out_q.status;

endmodule

### rtl/mma_ram.sv
module mma_ram #(
  parameter int Width = 16,
  parameter int Depth = 4096
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/mma_argmax.sv
module mma_argmax (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mma_pkg::scan_beat_t        beat_i,
  input  logic [mma_pkg::ValW-1:0]   data_i,
  output mma_pkg::argmax_res_t       res_o
);
  import mma_pkg::*;

  logic [ValW-1:0]  best_q;
  logic [CentW-1:0] col_q;
  logic             done_q;
  logic             fin_q;
  logic             take;

  // strict greater keeps the lowest column on a tie
  assign take = beat_i.valid && (beat_i.first || (data_i > best_q));

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_q <= data_i;
      col_q  <= beat_i.col;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      fin_q  <= 1'b0;
    end else begin
      done_q <= beat_i.valid && beat_i.last;
      fin_q  <= beat_i.valid && beat_i.fin;
    end
  end

  assign res_o.done = done_q;
  assign res_o.fin  = fin_q;
  assign res_o.col  = col_q;

endmodule

### rtl/mma_seq.sv
module mma_seq #(
  parameter int MAX_POINTS    = 256,
  parameter int MAX_CENTROIDS = 16,
  parameter int AW            = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [mma_pkg::ActW-1:0]     action_i,
  input  logic [mma_pkg::PointW-1:0]   point_i,
  input  logic [mma_pkg::CentW-1:0]    centroid_i,
  input  logic [mma_pkg::ValW-1:0]     value_i,
  input  logic [mma_pkg::PointW-1:0]   np_i,
  input  logic [mma_pkg::CentW-1:0]    nc_i,
  input  logic                         base_i,
  input  logic                         out_free_i,
  input  mma_pkg::argmax_res_t         res_i,
  input  logic [mma_pkg::ValW-1:0]     rdata_i,
  output logic                         ram_we_o,
  output logic [AW-1:0]                ram_waddr_o,
  output logic [mma_pkg::ValW-1:0]     ram_wdata_o,
  output logic                         ram_re_o,
  output logic [AW-1:0]                ram_raddr_o,
  output mma_pkg::scan_beat_t          beat_o,
  output logic                         load_o,
  output mma_pkg::result_t             result_o
);
  import mma_pkg::*;

  seq_state_e        state_q, state_d;
  act_e              act_q, act_d;
  logic              oob_q, oob_d;
  logic [CentW-1:0]  tgt_q, tgt_d;
  logic [PointW-1:0] row_q, row_d;
  logic [CentW-1:0]  col_q, col_d;
  logic [AW-1:0]     row_addr_q, row_addr_d;
  logic [PointW-1:0] cnt_q, cnt_d;
  scan_beat_t        beat_q, beat_d;

  act_e              in_act;
  logic [PointW-1:0] p_ub;
  logic [CentW-1:0]  c_ub;
  logic              p_ok, c_ok, oob_in;
  logic              accept;
  logic [AW-1:0]     in_addr, row_start;
  logic              last_col, last_row, issue_fin;

  assign in_act = act_e'(action_i);

  // remove the index bias and check against the rows and columns in use
  assign p_ub = point_i - PointW'(base_i);
  assign c_ub = centroid_i - CentW'(base_i);
  assign p_ok = !(base_i && (point_i == '0)) && (p_ub < np_i);
  assign c_ok = !(base_i && (centroid_i == '0)) && (c_ub < nc_i);

  assign row_start = AW'(32'(p_ub) * MAX_CENTROIDS);
  assign in_addr   = AW'(32'(row_start) + 32'(c_ub));

  assign accept = (state_q == ST_IDLE) && in_valid_i;

  always_comb begin
    case (in_act)
      ACT_WRITE, ACT_READ: oob_in = !(p_ok && c_ok);
      ACT_HARD:            oob_in = !p_ok;
      ACT_COUNT:           oob_in = !c_ok;
      default:             oob_in = 1'b1;
    endcase
  end

  assign last_col  = (col_q == nc_i - CentW'(1));
  assign last_row  = (row_q == np_i - PointW'(1));
  assign issue_fin = last_col && ((act_q == ACT_HARD) || last_row);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (oob_in || (in_act == ACT_WRITE) || (in_act == ACT_READ)) begin
            state_d = ST_RESULT;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (issue_fin) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (res_i.fin) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o   = (state_q == ST_IDLE);
    ram_we_o     = accept && (in_act == ACT_WRITE) && p_ok && c_ok;
    ram_waddr_o  = in_addr;
    ram_wdata_o  = value_i;
    ram_re_o     = (accept && (in_act == ACT_READ) && p_ok && c_ok) || (state_q == ST_SCAN);
    ram_raddr_o  = in_addr;
    beat_d       = '0;
    if (state_q == ST_SCAN) begin
      ram_raddr_o  = AW'(32'(row_addr_q) + 32'(col_q));
      beat_d.valid = 1'b1;
      beat_d.first = (col_q == '0);
      beat_d.last  = last_col;
      beat_d.fin   = issue_fin;
      beat_d.col   = col_q;
    end
    load_o = (state_q == ST_RESULT) && out_free_i;

    result_o.read_value    = ((act_q == ACT_READ) && !oob_q) ? rdata_i : '0;
    result_o.cluster_index = ((act_q == ACT_HARD) && !oob_q) ? res_i.col + CentW'(base_i) : '0;
    result_o.point_count   = ((act_q == ACT_COUNT) && !oob_q) ? cnt_q : '0;
    result_o.status        = oob_q;
  end

  // scan counters and the member count
  always_comb begin
    act_d      = act_q;
    oob_d      = oob_q;
    tgt_d      = tgt_q;
    row_d      = row_q;
    col_d      = col_q;
    row_addr_d = row_addr_q;
    cnt_d      = cnt_q;

    if (res_i.done && (act_q == ACT_COUNT) && (res_i.col == tgt_q)) begin
      cnt_d = cnt_q + PointW'(1);
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          act_d = in_act;
          oob_d = oob_in;
          tgt_d = c_ub;
          col_d = '0;
          cnt_d = '0;
          if (in_act == ACT_HARD) begin
            row_d      = p_ub;
            row_addr_d = row_start;
          end else begin
            row_d      = '0;
            row_addr_d = '0;
          end
        end
      end
      ST_SCAN: begin
        if (last_col) begin
          col_d      = '0;
          row_d      = row_q + PointW'(1);
          row_addr_d = AW'(32'(row_addr_q) + MAX_CENTROIDS);
        end else begin
          col_d = col_q + CentW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      beat_q  <= '0;
    end else begin
      state_q <= state_d;
      beat_q  <= beat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    oob_q      <= oob_d;
    tgt_q      <= tgt_d;
    row_q      <= row_d;
    col_q      <= col_d;
    row_addr_q <= row_addr_d;
    cnt_q      <= cnt_d;
  end

  assign beat_o = beat_q;

endmodule

### verif/membership_matrix_argmax_test.sv
module membership_matrix_argmax_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mma_pkg::*;

  localparam int RowStride     = DefMaxCentroids;
  localparam int StoreDepth    = DefMaxPoints * DefMaxCentroids;
  localparam int HoldOffCycles = 300;

  typedef struct packed {
    act_e              action;
    logic [PointW-1:0] point;
    logic [CentW-1:0]  centroid;
    logic [ValW-1:0]   value;
  } item_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [CfgDataW-1:0]  cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // action[1:0], point[10:2], centroid[15:11], membership_value[31:16]
  logic [InDataW-1:0]   s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // read_value[15:0], cluster_index[20:16], point_count[29:21], zero fill
  logic [OutDataW-1:0]  m_axis_tdata;
  // status[0]
  logic [OutUserW-1:0]  m_axis_tuser;

  // shadow of the matrix and the registers
  logic [ValW-1:0]   membership_copy [StoreDepth];
  bit                filled [StoreDepth];
  logic [PointW-1:0] cfg_points    = PointsReset;
  logic [CentW-1:0]  cfg_centroids = CentroidsReset;
  logic              cfg_base      = 1'b0;

  result_t expected_results [$];

  int mismatches;
  int results_checked;
  int items_by_action [4];
  int out_of_range_items;
  bit idle_on      = 1'b1;
  bit hold_results = 1'b0;

  membership_matrix_argmax i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int unsigned rows_used();
    if (cfg_points == 0) return 1;
    if (cfg_points > DefMaxPoints) return DefMaxPoints;
    return cfg_points;
  endfunction

  function automatic int unsigned cols_used();
    if (cfg_centroids == 0) return 1;
    if (cfg_centroids > DefMaxCentroids) return DefMaxCentroids;
    return cfg_centroids;
  endfunction

  // removes the index bias, true when the result lies below limit
  function automatic bit strip_base(int unsigned raw, int unsigned limit,
                                    output int unsigned idx);
    idx = 0;
    if (raw < cfg_base) return 1'b0;
    idx = raw - cfg_base;
    return idx < limit;
  endfunction

  function automatic bit row_complete(int unsigned p, int unsigned nc);
    int unsigned c;
    for (c = 0; c < nc; c++) begin
      if (!filled[p * RowStride + c]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // first maximum wins a tie
  function automatic int unsigned row_argmax(int unsigned p, int unsigned nc);
    logic [ValW-1:0] best;
    int unsigned     col;
    int unsigned     c;
    best = membership_copy[p * RowStride];
    col  = 0;
    for (c = 1; c < nc; c++) begin
      if (membership_copy[p * RowStride + c] > best) begin
        best = membership_copy[p * RowStride + c];
        col  = c;
      end
    end
    return col;
  endfunction

  function automatic result_t predict_membership(item_t it);
    result_t     r;
    int unsigned np, nc, p, c, q;
    r  = '0;
    np = rows_used();
    nc = cols_used();
    case (it.action)
      ACT_WRITE, ACT_READ: begin
        if (strip_base(it.point, np, p) && strip_base(it.centroid, nc, c)) begin
          if (it.action == ACT_WRITE) begin
            membership_copy[p * RowStride + c] = it.value;
            filled[p * RowStride + c] = 1'b1;
          end else begin
            r.read_value = membership_copy[p * RowStride + c];
          end
        end else begin
          r.status = 1'b1;
        end
      end
      ACT_HARD: begin
        if (strip_base(it.point, np, p)) begin
          r.cluster_index = CentW'(row_argmax(p, nc) + cfg_base);
        end else begin
          r.status = 1'b1;
        end
      end
      default: begin
        // only the cluster is range checked for a count
        if (strip_base(it.centroid, nc, c)) begin
          for (q = 0; q < np; q++) begin
            if (row_argmax(q, nc) == c) r.point_count = r.point_count + 1'b1;
          end
        end else begin
          r.status = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  // true when the item would look at an entry never written
  function automatic bit reads_blank(item_t it);
    int unsigned np, nc, p, c, q;
    np = rows_used();
    nc = cols_used();
    case (it.action)
      ACT_READ: begin
        if (strip_base(it.point, np, p) && strip_base(it.centroid, nc, c))
          return !filled[p * RowStride + c];
      end
      ACT_HARD: begin
        if (strip_base(it.point, np, p)) return !row_complete(p, nc);
      end
      ACT_COUNT: begin
        if (strip_base(it.centroid, nc, c)) begin
          for (q = 0; q < np; q++) begin
            if (!row_complete(q, nc)) return 1'b1;
          end
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // small values and the extremes make ties likely
  function automatic logic [ValW-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return ValW'($urandom_range(0, 3));
      1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return ValW'($urandom);
    endcase
  endfunction

  function automatic item_t make_item(act_e a, int unsigned p, int unsigned c,
                                      logic [ValW-1:0] v);
    item_t it;
    it.action   = a;
    it.point    = PointW'(p);
    it.centroid = CentW'(c);
    it.value    = v;
    return it;
  endfunction

  function automatic item_t random_item();
    item_t       it;
    int unsigned np, nc, lim, p;
    np  = rows_used();
    nc  = cols_used();
    lim = (np < 8) ? np : 8;
    if ($urandom_range(0, 7) == 0) begin
      it.action   = act_e'($urandom_range(0, 3));
      it.point    = PointW'($urandom_range(0, 511));
      it.centroid = CentW'($urandom_range(0, 31));
    end else begin
      case ($urandom_range(0, 19)) inside
        [0:6]:   it.action = ACT_WRITE;
        [7:11]:  it.action = ACT_READ;
        [12:16]: it.action = ACT_HARD;
        default: it.action = ACT_COUNT;
      endcase
      p = ($urandom_range(0, 3) == 0) ? $urandom_range(0, np - 1) : $urandom_range(0, lim - 1);
      it.point    = PointW'(p + cfg_base);
      it.centroid = CentW'($urandom_range(0, nc - 1) + cfg_base);
    end
    it.value = pick_value();
    if (reads_blank(it)) it.action = ACT_WRITE;
    return it;
  endfunction

  task automatic send_item(input item_t it);
    result_t want;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tdata  <= {it.value, it.centroid, it.point, it.action};
    s_axis_tvalid <= 1'b1;
    want = predict_membership(it);
    expected_results.push_back(want);
    items_by_action[it.action]++;
    if (want.status) out_of_range_items++;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic hold_input();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [CfgDataW-1:0] pts, input logic [CfgDataW-1:0] cen,
                            input logic [CfgDataW-1:0] base);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgPoints;
    cfg_data_i <= pts;
    @(posedge clk_i);
    cfg_idx_i  <= CfgCentroids;
    cfg_data_i <= cen;
    @(posedge clk_i);
    cfg_idx_i  <= CfgIndexBase;
    cfg_data_i <= base;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_points    = pts;
    cfg_centroids = cen[CentW-1:0];
    cfg_base      = base[0];
  endtask

  task automatic run_random_phase(input logic [CfgDataW-1:0] pts,
                                  input logic [CfgDataW-1:0] cen,
                                  input logic [CfgDataW-1:0] base,
                                  input int n_items, input bit fill_rest);
    int unsigned np, nc, p, c;
    int          k;
    set_config(pts, cen, base);
    np = rows_used();
    nc = cols_used();
    // first row peaks in its last column
    for (c = 0; c < nc; c++) begin
      send_item(make_item(ACT_WRITE, cfg_base, c + cfg_base,
                          (c == nc - 1) ? 16'hFFFF : ValW'($urandom_range(0, 16'hFFFE))));
    end
    send_item(make_item(ACT_HARD, cfg_base, 0, '0));
    if (fill_rest) begin
      for (p = 0; p < np; p++) begin
        for (c = 0; c < nc; c++) begin
          if (!filled[p * RowStride + c])
            send_item(make_item(ACT_WRITE, p + cfg_base, c + cfg_base, pick_value()));
        end
      end
    end
    for (k = 0; k < n_items; k++) send_item(random_item());
    hold_input();
  endtask

  task automatic test_directed_corners();
    send_item(make_item(ACT_WRITE, 0, 0, 16'hFFFF));
    send_item(make_item(ACT_WRITE, 255, 15, 16'h0000));
    send_item(make_item(ACT_WRITE, 255, 0, 16'hA5A5));
    send_item(make_item(ACT_READ, 0, 0, '0));
    send_item(make_item(ACT_READ, 255, 15, 16'hFFFF));
    send_item(make_item(ACT_READ, 256, 0, '0));
    send_item(make_item(ACT_READ, 0, 16, '0));
    // out of range write must leave the matrix alone
    send_item(make_item(ACT_WRITE, 511, 31, 16'hFFFF));
    send_item(make_item(ACT_WRITE, 0, 31, 16'h1234));
    send_item(make_item(ACT_READ, 0, 0, '0));
    send_item(make_item(ACT_HARD, 256, 0, '0));
    send_item(make_item(ACT_HARD, 511, 31, '0));
    send_item(make_item(ACT_COUNT, 0, 16, '0));
    send_item(make_item(ACT_COUNT, 511, 31, '0));
    hold_input();
  endtask

  task automatic test_base_and_ties();
    set_config(9'd2, 9'd2, 9'd1);
    send_item(make_item(ACT_WRITE, 1, 1, 16'h1234));
    send_item(make_item(ACT_WRITE, 1, 2, 16'h1234));
    send_item(make_item(ACT_WRITE, 2, 1, 16'h0000));
    send_item(make_item(ACT_WRITE, 2, 2, 16'h0001));
    send_item(make_item(ACT_HARD, 1, 0, '0));
    send_item(make_item(ACT_HARD, 2, 0, '0));
    send_item(make_item(ACT_COUNT, 0, 1, '0));
    send_item(make_item(ACT_COUNT, 0, 2, '0));
    // indices under the base, then a row past the rows in use and the last cell
    send_item(make_item(ACT_READ, 0, 1, '0));
    send_item(make_item(ACT_READ, 1, 0, '0));
    send_item(make_item(ACT_HARD, 0, 1, '0));
    send_item(make_item(ACT_COUNT, 1, 0, '0));
    send_item(make_item(ACT_READ, 3, 1, '0));
    send_item(make_item(ACT_READ, 2, 2, '0));
    hold_input();
  endtask

  task automatic test_small_matrix();
    run_random_phase(9'd4, 9'd3, 9'd0, 100, 1'b1);
  endtask

  task automatic test_clamped_registers();
    // zero rows and zero columns behave as one of each
    run_random_phase(9'd0, 9'd0, 9'd1, 60, 1'b1);
  endtask

  task automatic test_wide_rows();
    run_random_phase(9'd12, 9'h03F, 9'd1, 120, 1'b1);
  endtask

  task automatic test_single_column_count();
    run_random_phase(9'd511, 9'd1, 9'd1, 60, 1'b1);
  endtask

  task automatic test_two_column_counts();
    run_random_phase(9'd200, 9'd2, 9'd0, 90, 1'b1);
  endtask

  task automatic test_full_matrix();
    // no fill here, counts turn into writes until every row is complete
    run_random_phase(9'd256, 9'd16, 9'd0, 120, 1'b0);
  endtask

  task automatic test_output_backpressure();
    int k;
    hold_results = 1'b1;
    for (k = 0; k < 12; k++) send_item(random_item());
    hold_input();
    wait_drained();
  endtask

  task automatic test_streaming_no_idle();
    idle_on = 1'b0;
    run_random_phase(9'd5, 9'd5, 9'd0, 88, 1'b1);
  endtask

  task automatic compare_field(input string what, input logic [ValW-1:0] want,
                               input logic [ValW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual %0h/%0h", $time,
                 m_axis_tdata, m_axis_tuser);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        compare_field("read_value", want.read_value, m_axis_tdata[15:0]);
        compare_field("cluster_index", want.cluster_index, m_axis_tdata[20:16]);
        compare_field("point_count", want.point_count, m_axis_tdata[29:21]);
        compare_field("status", want.status, m_axis_tuser[0]);
      end
    end
  end

  // receiver side: random stalls, plus one long hold-off on request
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_results) begin
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_results = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CfgPoints;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_corners();
    test_base_and_ties();
    test_small_matrix();
    test_clamped_registers();
    test_wide_rows();
    test_single_column_count();
    test_two_column_counts();
    test_full_matrix();
    test_output_backpressure();
    test_streaming_no_idle();

    wait_drained();
    repeat (16) @(posedge clk_i);

    $display("checked %0d results: %0d writes, %0d reads, %0d hard cluster, %0d counts",
             results_checked, items_by_action[ACT_WRITE], items_by_action[ACT_READ],
             items_by_action[ACT_HARD], items_by_action[ACT_COUNT]);
    $display("%0d out of range beats; settings from one cell to %0dx%0d, both bases",
             out_of_range_items, DefMaxPoints, DefMaxCentroids);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/mma_pkg.sv
rtl/mma_ram.sv
rtl/mma_argmax.sv
rtl/mma_seq.sv
rtl/membership_matrix_argmax.sv
verif/membership_matrix_argmax_test.sv
